[sv/assert_macros.svh]
// Assertion macros shared by the point finder RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ECPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecpf assertion failed");
`define ECPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecpf assertion failed");
`else
`define ECPF_ASSERT_IMP(label, ante, cons)
`define ECPF_ASSERT_NXT(label, ante, cons)
`endif
`endif

[sv/ecpf_pkg.sv]
// Shared types, step numbers and the microcode table of the point finder.
// No dependencies.
package ecpf_pkg;

    typedef logic [3:0] pc_t;

    typedef enum logic [3:0] {
        OP_IDLE    = 4'd0,
        OP_RANGE   = 4'd1,
        OP_MUL     = 4'd2,
        OP_REMUL   = 4'd3,
        OP_RHS     = 4'd4,
        OP_SCAN    = 4'd5,
        OP_NOP     = 4'd6,
        OP_FOUND   = 4'd7,
        OP_EMIT    = 4'd8,
        OP_ADVANCE = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT   = 3'd0,
        C_ALWAYS = 3'd1,
        C_IN     = 3'd2,
        C_GE     = 3'd3,
        C_CNT    = 3'd4,
        C_SCAN   = 3'd5,
        C_MORE   = 3'd6,
        C_OUT    = 3'd7
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctl_word_t;

    typedef struct packed {
        logic in_valid;
        logic x_ge;
        logic cnt_nz;
        logic hit;
        logic last;
        logic more;
        logic out_free;
    } status_t;

    localparam pc_t STEP_IDLE    = 4'd0;
    localparam pc_t STEP_RANGE   = 4'd1;
    localparam pc_t STEP_MUL1    = 4'd2;
    localparam pc_t STEP_REMUL   = 4'd3;
    localparam pc_t STEP_MUL2    = 4'd4;
    localparam pc_t STEP_RHS     = 4'd5;
    localparam pc_t STEP_SCAN    = 4'd6;
    localparam pc_t STEP_MISS    = 4'd7;
    localparam pc_t STEP_FOUND   = 4'd8;
    localparam pc_t STEP_EMIT    = 4'd9;
    localparam pc_t STEP_ADVANCE = 4'd10;

    // microcode program
    function automatic ctl_word_t ucode_rom(input pc_t pc);
        ctl_word_t w;
        begin
            unique case (pc)
                STEP_IDLE:    w = '{op: OP_IDLE,    cond: C_IN,     target: STEP_RANGE};
                STEP_RANGE:   w = '{op: OP_RANGE,   cond: C_GE,     target: STEP_EMIT};
                STEP_MUL1:    w = '{op: OP_MUL,     cond: C_CNT,    target: STEP_MUL1};
                STEP_REMUL:   w = '{op: OP_REMUL,   cond: C_NEXT,   target: STEP_MUL2};
                STEP_MUL2:    w = '{op: OP_MUL,     cond: C_CNT,    target: STEP_MUL2};
                STEP_RHS:     w = '{op: OP_RHS,     cond: C_NEXT,   target: STEP_SCAN};
                STEP_SCAN:    w = '{op: OP_SCAN,    cond: C_SCAN,   target: STEP_FOUND};
                STEP_MISS:    w = '{op: OP_NOP,     cond: C_ALWAYS, target: STEP_EMIT};
                STEP_FOUND:   w = '{op: OP_FOUND,   cond: C_MORE,   target: STEP_ADVANCE};
                STEP_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT,    target: STEP_IDLE};
                STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: C_ALWAYS, target: STEP_SCAN};
                default:      w = '{op: OP_NOP,     cond: C_ALWAYS, target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

[sv/ecpf_seq.sv]
// Step counter and branch logic for the point finder microcode.
// Depends on ecpf_pkg (table, types) and assert_macros.svh.
`include "assert_macros.svh"
module ecpf_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  ecpf_pkg::status_t   status,
    output ecpf_pkg::ctl_word_t ctl
);

    ecpf_pkg::pc_t pc_reg;
    ecpf_pkg::pc_t pc_next;
    ecpf_pkg::pc_t pc_inc;

    assign ctl    = ecpf_pkg::ucode_rom(pc_reg);
    assign pc_inc = pc_reg + ecpf_pkg::pc_t'(1);

    always_comb
    begin
        unique case (ctl.cond)
            ecpf_pkg::C_NEXT:   pc_next = pc_inc;
            ecpf_pkg::C_ALWAYS: pc_next = ctl.target;
            ecpf_pkg::C_IN:     pc_next = status.in_valid ? ctl.target : pc_reg;
            ecpf_pkg::C_GE:     pc_next = status.x_ge ? ctl.target : pc_inc;
            ecpf_pkg::C_CNT:    pc_next = status.cnt_nz ? ctl.target : pc_inc;
            ecpf_pkg::C_SCAN:   pc_next = status.hit ? ctl.target :
                                          (status.last ? pc_inc : pc_reg);
            ecpf_pkg::C_MORE:   pc_next = status.more ? ctl.target : pc_inc;
            ecpf_pkg::C_OUT:    pc_next = status.out_free ? ctl.target : pc_reg;
            default:            pc_next = ecpf_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ecpf_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // an accepted beat always starts the range check next
    `ECPF_ASSERT_NXT(a_accept_starts, status.in_valid && ctl.op == ecpf_pkg::OP_IDLE, pc_reg == ecpf_pkg::STEP_RANGE)

endmodule

[sv/ecpf_datapath.sv]
// Datapath of the point finder: modular multiply steps, rhs, incremental
// square scan and the output register. Depends on ecpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ecpf_datapath
#(
    parameter int N = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ecpf_pkg::ctl_word_t ctl,
    output ecpf_pkg::status_t   status,
    input  logic [N-1:0]        modulus,
    input  logic                curve_constant,
    input  logic                in_valid,
    input  logic [N-1:0]        in_x,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [N-1:0]        out_x,
    output logic [1:0]          out_count,
    output logic [N-1:0]        out_r1,
    output logic [N-1:0]        out_r2
);

    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0]     x_reg;
    logic [N-1:0]     acc_reg;
    logic [N-1:0]     a_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N-1:0]     rhs_reg;
    logic [N-1:0]     y_reg;
    logic [N-1:0]     sq_reg;
    logic [N-1:0]     d_reg;
    logic             phase_reg;
    logic [1:0]       count_reg;
    logic [N-1:0]     r1_reg;
    logic [N-1:0]     r2_reg;
    logic             out_valid_reg;
    logic [N-1:0]     out_x_reg;
    logic [1:0]       out_count_reg;
    logic [N-1:0]     out_r1_reg;
    logic [N-1:0]     out_r2_reg;

    logic [N:0] m_ext;
    logic [N:0] dbl, dbl_red, add, add_red;
    logic [N:0] diff, sumb, rhs_val;
    logic [N:0] y_inc, sq_sum, sq_red, d_sum, d_red;
    logic       out_free;
    logic       emit_fire;
    logic       hit;

    assign m_ext = {1'b0, modulus};

    // one double-and-add step of a modular multiply, MSB first
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        add     = dbl_red + (x_reg[cnt_reg] ? {1'b0, a_reg} : '0);
        add_red = (add >= m_ext) ? add - m_ext : add;
    end

    // rhs = cube - x + b mod m
    always_comb
    begin
        diff    = (acc_reg >= x_reg) ? {1'b0, acc_reg} - {1'b0, x_reg}
                                     : {1'b0, acc_reg} + m_ext - {1'b0, x_reg};
        sumb    = diff + (N+1)'(curve_constant);
        rhs_val = (sumb >= m_ext) ? sumb - m_ext : sumb;
    end

    // (y+1)^2 = y^2 + d, d = 2y+1 mod m
    always_comb
    begin
        y_inc  = {1'b0, y_reg} + (N+1)'(1);
        sq_sum = {1'b0, sq_reg} + {1'b0, d_reg};
        sq_red = (sq_sum >= m_ext) ? sq_sum - m_ext : sq_sum;
        d_sum  = {1'b0, d_reg} + (N+1)'(2);
        d_red  = (d_sum >= m_ext) ? d_sum - m_ext : d_sum;
    end

    assign hit       = (sq_reg == rhs_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = (ctl.op == ecpf_pkg::OP_EMIT) && out_free;

    assign status.in_valid = in_valid;
    assign status.x_ge     = ({1'b0, x_reg} >= m_ext);
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.hit      = hit;
    assign status.last     = (y_inc == m_ext);
    assign status.more     = !phase_reg && (y_reg != '0) && (y_inc < m_ext);
    assign status.out_free = out_free;

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            ecpf_pkg::OP_IDLE:
            begin
                if (in_valid)
                begin
                    x_reg <= in_x;
                end
            end
            ecpf_pkg::OP_RANGE:
            begin
                acc_reg   <= '0;
                a_reg     <= x_reg;
                cnt_reg   <= CNT_W'(N - 1);
                count_reg <= 2'd0;
                r1_reg    <= '0;
                r2_reg    <= '0;
            end
            ecpf_pkg::OP_MUL:
            begin
                acc_reg <= add_red[N-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ecpf_pkg::OP_REMUL:
            begin
                a_reg   <= acc_reg;
                acc_reg <= '0;
                cnt_reg <= CNT_W'(N - 1);
            end
            ecpf_pkg::OP_RHS:
            begin
                rhs_reg   <= rhs_val[N-1:0];
                y_reg     <= '0;
                sq_reg    <= '0;
                d_reg     <= (modulus == N'(1)) ? '0 : N'(1);
                phase_reg <= 1'b0;
            end
            ecpf_pkg::OP_SCAN:
            begin
                if (!hit)
                begin
                    y_reg  <= y_inc[N-1:0];
                    sq_reg <= sq_red[N-1:0];
                    d_reg  <= d_red[N-1:0];
                end
            end
            ecpf_pkg::OP_FOUND:
            begin
                if (!phase_reg)
                begin
                    r1_reg    <= y_reg;
                    count_reg <= 2'd1;
                end
                else
                begin
                    r2_reg    <= y_reg;
                    count_reg <= 2'd2;
                end
            end
            ecpf_pkg::OP_ADVANCE:
            begin
                y_reg     <= y_inc[N-1:0];
                sq_reg    <= sq_red[N-1:0];
                d_reg     <= d_red[N-1:0];
                phase_reg <= 1'b1;
            end
            ecpf_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_x_reg     <= x_reg;
                    out_count_reg <= count_reg;
                    out_r1_reg    <= r1_reg;
                    out_r2_reg    <= r2_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_count = out_count_reg;
    assign out_r1    = out_r1_reg;
    assign out_r2    = out_r2_reg;

    `ECPF_ASSERT_IMP(a_scan_y_in_ring, ctl.op == ecpf_pkg::OP_SCAN, {1'b0, y_reg} < m_ext)
    `ECPF_ASSERT_IMP(a_scan_sq_in_ring, ctl.op == ecpf_pkg::OP_SCAN, {1'b0, sq_reg} < m_ext)

endmodule

[sv/elliptic_curve_point_finder_unit.sv]
// Top level of the elliptic curve point finder: config registers, sequencer,
// datapath and beat packing. Depends on ecpf_pkg, ecpf_seq, ecpf_datapath.
//
// Usage: s_* carries one x coordinate per beat; m_* returns one result beat
// per input: x echo, root count (0..2), smallest root, next larger root.
// Config writes go over cfg_valid/cfg_index/cfg_data (0 = modulus,
// 1 = curve constant b); cfg_ready is always high, write only while idle.
// After the accept, the range check, a first multiply, a reload step, a
// second multiply and the rhs step build the modular cube and rhs, then the
// incremental-square scan walks one candidate y per cycle; both searches
// together walk at most modulus candidates. Recording a root, stepping past
// the first root or a miss take one step each, and the emit step loads the
// output register; an x at or above modulus jumps there from the range check.
// One item is in work at a time; s_tready is high only while the
// sequencer waits at its idle step.
// Results sit in an output register: the next item is accepted and
// computed while it waits, and only the load of the following result
// stalls while m_tready stays low.
// Reset clears the sequencer and the output valid; modulus returns to 7,
// b to 0.
`include "assert_macros.svh"
module elliptic_curve_point_finder_unit
#(
    parameter int MODULUS_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [MODULUS_BITS-1:0] x_coord
    input  logic [((MODULUS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // x_echo, root_count (2 bits), first_root, second_root, zero pad
    output logic [((3 * MODULUS_BITS + 9) / 8) * 8 - 1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [MODULUS_BITS-1:0] cfg_data
);

    localparam int N     = MODULUS_BITS;
    localparam int OUT_W = ((3 * MODULUS_BITS + 9) / 8) * 8;
    localparam logic [N-1:0] MOD_RESET = N'(7);

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE   = 1'b1;

    logic [N-1:0] modulus_reg;
    logic         curve_reg;

    ecpf_pkg::ctl_word_t ctl;
    ecpf_pkg::status_t   status;

    logic [N-1:0] out_x, out_r1, out_r2;
    logic [1:0]   out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            curve_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_CURVE:   curve_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = (ctl.op == ecpf_pkg::OP_IDLE);

    ecpf_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    ecpf_datapath #(.N(N)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .modulus        (modulus_reg),
        .curve_constant (curve_reg),
        .in_valid       (s_tvalid),
        .in_x           (s_tdata[N-1:0]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_x          (out_x),
        .out_count      (out_count),
        .out_r1         (out_r1),
        .out_r2         (out_r2)
    );

    assign m_tdata = OUT_W'({out_r2, out_r1, out_count, out_x});

    `ECPF_ASSERT_IMP(a_count_range, m_tvalid, out_count != 2'd3)
    `ECPF_ASSERT_IMP(a_roots_ordered, m_tvalid && out_count == 2'd2, out_r2 > out_r1)

endmodule

[tb/sv/elliptic_curve_point_finder_unit_tb.sv]
// Self-checking testbench for elliptic_curve_point_finder_unit: directed corners, then random
// curve settings and x coordinates, all checked against an in-bench root search.
// Depends only on the RTL top level and what it pulls in.
`timescale 1ns / 100ps
module elliptic_curve_point_finder_unit_tb;

    localparam int W           = 10;
    localparam int S_W         = ((W + 7) / 8) * 8;
    localparam int M_W         = ((3 * W + 9) / 8) * 8;
    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_CURVE   = 1'b1;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        logic [W-1:0] x;
        logic [1:0]   count;
        logic [W-1:0] r1;
        logic [W-1:0] r2;
    } point_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata   = '0;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic           cfg_index = 1'b0;
    logic [W-1:0]   cfg_data  = '0;

    // shadow of the block's registers, reset values
    logic [W-1:0]   cur_modulus = W'(7);
    logic           cur_b       = 1'b0;

    point_t         pending_points[$];
    int             err_count    = 0;
    bit             src_idle_en  = 1'b1;
    bit             sink_idle_en = 1'b1;
    int             sink_hold    = 0;

    elliptic_curve_point_finder_unit #(.MODULUS_BITS(W)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void report_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // y*y == x^3 - x + b (mod m): smallest root, then the next one above it
    function automatic point_t solve_point(input logic [W-1:0] x);
        point_t      p;
        int unsigned m;
        int unsigned xv;
        int unsigned rhs;
        int unsigned y;
        bit          hit;
        p.x     = x;
        p.count = 2'd0;
        p.r1    = '0;
        p.r2    = '0;
        m       = cur_modulus;
        xv      = x;
        if (xv < m)
        begin
            rhs = ((((xv * xv) % m) * xv) % m + m - xv + cur_b) % m;
            hit = 1'b0;
            for (y = 0; y < m && !hit; y++)
            begin
                if ((y * y) % m == rhs)
                begin
                    hit  = 1'b1;
                    p.r1 = W'(y);
                end
            end
            if (hit)
            begin
                p.count = 2'd1;
                // roots 0 and m-1 have no partner search
                if (p.r1 > 0 && p.r1 + 1 < m)
                begin
                    hit = 1'b0;
                    for (y = p.r1 + 1; y < m && !hit; y++)
                    begin
                        if ((y * y) % m == rhs)
                        begin
                            hit     = 1'b1;
                            p.r2    = W'(y);
                            p.count = 2'd2;
                        end
                    end
                end
            end
        end
        return p;
    endfunction

    function automatic logic [W-1:0] pick_x(input logic [W-1:0] m);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return W'($urandom_range(0, m - 1));
        else if (r == 7)
            return ($urandom_range(0, 1) != 0) ? W'(m - 1) : '0;
        else if (r == 8)
            return W'($urandom_range(m, (1 << W) - 1));
        else
            return W'($urandom_range(0, (1 << W) - 1));
    endfunction

    task automatic send_x(input logic [W-1:0] x);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(x);
        do @(posedge clk); while (!s_tready);
        pending_points.insert(pending_points.size(), solve_point(x));
    endtask

    // drop valid and wait for every outstanding result beat
    task automatic settle_stream();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
    endtask

    task automatic program_curve(input logic [W-1:0] m, input logic b);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cur_modulus = m;
        cfg_index <= REG_CURVE;
        cfg_data  <= W'(b);
        do @(posedge clk); while (!cfg_ready);
        cur_b = b;
        cfg_valid <= 1'b0;
    endtask

    // reset values m=7, b=0: roots, a non-residue, out-of-range x
    task automatic test_reset_config();
        send_x(W'(0));
        send_x(W'(1));
        send_x(W'(2));
        send_x(W'(3));
        send_x(W'(5));
        send_x(W'(6));
        send_x(W'(7));
        send_x(W'(1023));
        settle_stream();
    endtask

    task automatic test_tiny_moduli();
        program_curve(W'(0), 1'b0);
        send_x(W'(0));
        send_x(W'(1023));
        settle_stream();
        program_curve(W'(1), 1'b1);
        send_x(W'(0));
        send_x(W'(1));
        settle_stream();
        // first root lands on m-1
        program_curve(W'(2), 1'b1);
        send_x(W'(0));
        send_x(W'(1));
        settle_stream();
    endtask

    // composite modulus: root 5 of 10 has no larger partner
    task automatic test_lone_roots();
        program_curve(W'(10), 1'b1);
        send_x(W'(3));
        send_x(W'(9));
        settle_stream();
    endtask

    task automatic test_wide_modulus();
        program_curve(W'(1023), 1'b1);
        send_x(W'(0));
        send_x(W'(1022));
        send_x(W'(1023));
        send_x(W'(682));
        settle_stream();
        program_curve(W'(1021), 1'b0);
        send_x(W'(1020));
        send_x(W'(341));
        settle_stream();
    endtask

    task automatic test_random_sweep(input int budget);
        int           done;
        int           n;
        int           pick;
        logic [W-1:0] m;
        done = 0;
        while (done < budget)
        begin
            pick = $urandom_range(0, 15);
            // wide moduli mean long root scans, so keep those phases short
            if (pick == 0)
            begin
                m = W'($urandom_range(512, 1023));
                n = $urandom_range(6, 10);
            end
            else if (pick < 4)
            begin
                m = W'($urandom_range(2, 16));
                n = $urandom_range(20, 40);
            end
            else
            begin
                m = W'($urandom_range(17, 160));
                n = $urandom_range(20, 50);
            end
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            program_curve(m, 1'($urandom_range(0, 1)));
            repeat (n) send_x(pick_x(m));
            settle_stream();
            done += n;
        end
    endtask

    task automatic test_full_rate();
        logic [W-1:0] m;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        m = W'($urandom_range(40, 200));
        program_curve(m, 1'($urandom_range(0, 1)));
        repeat (60) send_x(pick_x(m));
        settle_stream();
    endtask

    // result sink with random stall bursts
    always @(posedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else if (sink_idle_en && $urandom_range(0, 9) == 0)
            sink_hold = $urandom_range(1, 18);
        m_tready <= (sink_hold == 0);
    end

    always @(posedge clk)
    begin : result_check
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_points.size() == 0)
                report_error($sformatf("result beat with no item waiting: %h", m_tdata));
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[W-1:0] !== want.x || m_tdata[W+1:W] !== want.count ||
                    m_tdata[2*W+1:W+2] !== want.r1 || m_tdata[3*W+1:2*W+2] !== want.r2)
                    report_error($sformatf(
                        "m=%0d b=%0d exp x=%0d n=%0d r1=%0d r2=%0d got x=%0d n=%0d r1=%0d r2=%0d",
                        cur_modulus, cur_b, want.x, want.count, want.r1, want.r2,
                        m_tdata[W-1:0], m_tdata[W+1:W], m_tdata[2*W+1:W+2],
                        m_tdata[3*W+1:2*W+2]));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("elliptic_curve_point_finder_unit_tb: errors");
        $finish;
    end

    initial
    begin : run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_tiny_moduli();
        test_lone_roots();
        test_wide_modulus();
        test_random_sweep(500);
        test_full_rate();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_points.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_points.size()));
        if (err_count == 0)
            $display("elliptic_curve_point_finder_unit_tb: clean");
        else
            $display("elliptic_curve_point_finder_unit_tb: errors");
        $finish;
    end

endmodule
